FILE: rtl/core/nesterov_momentum_update_assert.svh
// Assertion macros used by nesterov_momentum_update.sv.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef NESTEROV_MOMENTUM_UPDATE_ASSERT_SVH
`define NESTEROV_MOMENTUM_UPDATE_ASSERT_SVH

// Same-cycle implication.
`define NMU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NMU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/nmu_pkg.sv
package nmu_pkg;

  localparam int IDX_W     = 12;
  localparam int VAL_W     = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam int MUL_A_W = 18;
  localparam int MUL_P_W = MUL_A_W + VAL_W;
  localparam int ACC_W   = 52;
  localparam int RND_W   = ACC_W - 16;
  localparam int SAT_W   = 40;

  localparam logic [CFG_W-1:0] LR_RESET  = 16'd6554;
  localparam logic [CFG_W-1:0] RHO_RESET = 16'd58982;

  // One in Q1.16, added to rho for the (1 + rho) factor.
  localparam logic [CFG_W:0] ONE_Q16 = 17'h10000;

  // Half an LSB of Q8.24 when the value is held in Q.40.
  localparam logic signed [ACC_W-1:0] RND_HALF = 52'sd32768;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_SIZE      = 2'd0,
    CFG_MOMENTUM_DECAY = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic                      en;
    logic signed [MUL_A_W-1:0] a;
    logic signed [VAL_W-1:0]   b;
  } mul_req_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
    logic signed [VAL_W-1:0] r;
    if (x > 40'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (x < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/nmu_in_if.sv
interface nmu_in_if;
  logic                             valid;
  logic                             ready;
  logic                             cmd;
  logic [nmu_pkg::IDX_W-1:0]        param_index;
  logic signed [nmu_pkg::VAL_W-1:0] operand_value;

  modport source (output valid, output cmd, output param_index, output operand_value,
                  input ready);
  modport sink (input valid, input cmd, input param_index, input operand_value,
                output ready);
endinterface

FILE: rtl/core/nmu_out_if.sv
interface nmu_out_if;
  logic                             valid;
  logic                             ready;
  logic [nmu_pkg::IDX_W-1:0]        out_index;
  logic signed [nmu_pkg::VAL_W-1:0] new_weight;
  logic signed [nmu_pkg::VAL_W-1:0] new_velocity;

  modport source (output valid, output out_index, output new_weight, output new_velocity,
                  input ready);
  modport sink (input valid, input out_index, input new_weight, input new_velocity,
                output ready);
endinterface

FILE: rtl/core/nmu_ram.sv
module nmu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/core/nmu_mul.sv
module nmu_mul (
  input  logic                                 clk_i,
  input  nmu_pkg::mul_req_t                    req_i,
  output logic signed [nmu_pkg::MUL_P_W-1:0]   prod_o
);

  // Signed 18 x 32 multiply with the product registered.
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_o <= req_i.a * req_i.b;
    end
  end

endmodule

FILE: rtl/core/nesterov_momentum_update.sv
// Nesterov momentum update engine with on-chip weight and velocity stores.
// Input items arrive on req_i (valid/ready); an item is taken on a clock edge
// with valid and ready both high. Each item returns exactly one result item
// on rsp_o carrying the index, the weight after the item and the velocity
// after the item.
// An update item runs through one store read and then a sequencer that runs
// four products through a single shared 18 x 32 multiplier, two accumulate
// steps, two rounding steps and one weight add. A load item or an item whose
// index is beyond the store goes from acceptance straight to the done state.
// The result is registered: the output register is loaded as the item leaves
// the done state, and ready is high only while the sequencer is idle.
// If the receiver stalls, the finished result waits in the output register,
// and a following item runs up to its write-back and then holds until the
// output register frees, so no result is lost.
// After reset both stores are swept to zero, one entry per cycle; ready stays
// low during the sweep. Configuration writes on cfg_we_i are taken at any
// time, including during the sweep, and the registers come up with a step
// size of 6554 and a momentum factor of 58982.
module nesterov_momentum_update #(
  parameter int NUM_PARAMS = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  nmu_in_if.sink                            req_i,
  nmu_out_if.source                         rsp_o,
  input  logic                              cfg_we_i,
  input  logic [nmu_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [nmu_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int AW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
  localparam int XW = (AW > nmu_pkg::IDX_W) ? AW : nmu_pkg::IDX_W;
  localparam int VW = nmu_pkg::VAL_W;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_MUL_LG,
    S_VSUM,
    S_VRND,
    S_MUL_KV,
    S_MUL_RV,
    S_WSUM,
    S_WRND,
    S_WADD,
    S_DONE
  } state_e;

  state_e state_q;
  logic [AW-1:0] clr_q;
  logic out_valid_q;
  logic [nmu_pkg::CFG_W-1:0] lr_q;
  logic [nmu_pkg::CFG_W-1:0] rho_q;

  // Item registers and datapath.
  logic                          cmd_q;
  logic [nmu_pkg::IDX_W-1:0]     idx_q;
  logic                          in_range_q;
  logic signed [VW-1:0]          op_q;
  logic signed [VW-1:0]          v_old_q;
  logic signed [VW-1:0]          w_old_q;
  logic signed [VW-1:0]          v_new_q;
  logic signed [VW-1:0]          w_new_q;
  logic signed [nmu_pkg::ACC_W-1:0] acc_q;
  logic signed [nmu_pkg::RND_W-1:0] step_q;

  logic [nmu_pkg::IDX_W-1:0]     out_index_q;
  logic signed [VW-1:0]          out_weight_q;
  logic signed [VW-1:0]          out_velocity_q;

  logic accept;
  logic out_free;
  logic finish;
  logic req_in_range;

  logic [XW-1:0] req_idx_x;
  logic [XW-1:0] cur_idx_x;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          ram_we;
  logic [VW-1:0] w_wdata;
  logic [VW-1:0] v_wdata;
  logic [VW-1:0] w_rdata;
  logic [VW-1:0] v_rdata;

  nmu_pkg::mul_req_t mreq;
  logic signed [nmu_pkg::MUL_P_W-1:0] mul_p;

  logic signed [nmu_pkg::ACC_W-1:0] rnd_sum;
  logic signed [nmu_pkg::RND_W-1:0] rnd_val;
  logic signed [nmu_pkg::SAT_W-1:0] w_sum;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign finish      = (state_q == S_DONE) && out_free;

  assign req_idx_x    = XW'(req_i.param_index);
  assign cur_idx_x    = XW'(idx_q);
  assign rd_addr      = req_idx_x[AW-1:0];
  assign req_in_range = (32'(req_i.param_index) < 32'(NUM_PARAMS));

  // The sweep after reset writes zero; otherwise a finished in-range item writes back.
  assign ram_we  = (state_q == S_CLEAR) || (finish && in_range_q);
  assign wr_addr = (state_q == S_CLEAR) ? clr_q : cur_idx_x[AW-1:0];
  assign w_wdata = (state_q == S_CLEAR) ? '0 : w_new_q;
  assign v_wdata = (state_q == S_CLEAR) ? '0 : v_new_q;

  nmu_ram #(.WIDTH(VW), .DEPTH(NUM_PARAMS)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (w_wdata),
    .raddr_i (rd_addr),
    .rdata_o (w_rdata)
  );

  nmu_ram #(.WIDTH(VW), .DEPTH(NUM_PARAMS)) u_velocity_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (v_wdata),
    .raddr_i (rd_addr),
    .rdata_o (v_rdata)
  );

  // Operand selection for the shared multiplier. The product is registered and is
  // ready in the state after the operands are presented.
  always_comb begin
    mreq.en = 1'b0;
    mreq.a  = $signed({2'b00, rho_q});
    mreq.b  = v_old_q;
    case (state_q)
      S_READ: begin
        mreq.en = 1'b1;
        mreq.b  = $signed(v_rdata);
      end
      S_MUL_LG: begin
        mreq.en = 1'b1;
        mreq.a  = $signed({2'b00, lr_q});
        mreq.b  = op_q;
      end
      S_MUL_KV: begin
        mreq.en = 1'b1;
        mreq.a  = $signed({1'b0, 17'(rho_q) + nmu_pkg::ONE_Q16});
        mreq.b  = v_new_q;
      end
      S_MUL_RV: begin
        mreq.en = 1'b1;
      end
      default: begin
        mreq.en = 1'b0;
      end
    endcase
  end

  nmu_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mreq),
    .prod_o (mul_p)
  );

  // Round half up from Q.40 to Q8.24: add half an LSB, then an arithmetic
  // drop of sixteen bits, which is a floor.
  assign rnd_sum = acc_q + nmu_pkg::RND_HALF;
  assign rnd_val = rnd_sum[nmu_pkg::ACC_W-1:16];
  assign w_sum   = nmu_pkg::SAT_W'(w_old_q) + nmu_pkg::SAT_W'(step_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      lr_q        <= nmu_pkg::LR_RESET;
      rho_q       <= nmu_pkg::RHO_RESET;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          nmu_pkg::CFG_STEP_SIZE:      lr_q  <= cfg_data_i;
          nmu_pkg::CFG_MOMENTUM_DECAY: rho_q <= cfg_data_i;
          default: ;
        endcase
      end

      // A finishing item refills the output register in the same cycle that
      // the receiver takes the previous result.
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_CLEAR: begin
          if (clr_q == AW'(NUM_PARAMS - 1)) begin
            state_q <= S_IDLE;
          end else begin
            clr_q <= clr_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (!req_in_range || (req_i.cmd == nmu_pkg::CMD_LOAD)) begin
              state_q <= S_DONE;
            end else begin
              state_q <= S_READ;
            end
          end
        end
        S_READ:   state_q <= S_MUL_LG;
        S_MUL_LG: state_q <= S_VSUM;
        S_VSUM:   state_q <= S_VRND;
        S_VRND:   state_q <= S_MUL_KV;
        S_MUL_KV: state_q <= S_MUL_RV;
        S_MUL_RV: state_q <= S_WSUM;
        S_WSUM:   state_q <= S_WRND;
        S_WRND:   state_q <= S_WADD;
        S_WADD:   state_q <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_q      <= req_i.cmd;
          idx_q      <= req_i.param_index;
          in_range_q <= req_in_range;
          op_q       <= req_i.operand_value;
          v_new_q    <= '0;
          if (req_in_range && (req_i.cmd == nmu_pkg::CMD_LOAD)) begin
            w_new_q <= req_i.operand_value;
          end else begin
            w_new_q <= '0;
          end
        end
      end
      S_READ: begin
        v_old_q <= $signed(v_rdata);
        w_old_q <= $signed(w_rdata);
      end
      S_MUL_LG: acc_q   <= nmu_pkg::ACC_W'(mul_p);
      S_VSUM:   acc_q   <= acc_q - nmu_pkg::ACC_W'(mul_p);
      S_VRND:   v_new_q <= nmu_pkg::sat32(nmu_pkg::SAT_W'(rnd_val));
      S_MUL_RV: acc_q   <= nmu_pkg::ACC_W'(mul_p);
      S_WSUM:   acc_q   <= acc_q - nmu_pkg::ACC_W'(mul_p);
      S_WRND:   step_q  <= rnd_val;
      S_WADD:   w_new_q <= nmu_pkg::sat32(w_sum);
      S_DONE: begin
        if (out_free) begin
          out_index_q    <= idx_q;
          out_weight_q   <= w_new_q;
          out_velocity_q <= v_new_q;
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.out_index    = out_index_q;
  assign rsp_o.new_weight   = out_weight_q;
  assign rsp_o.new_velocity = out_velocity_q;

`include "nesterov_momentum_update_assert.svh"

  // Stores are written only by the reset sweep or by an in-range item finishing.
  `NMU_ASSERT_IMP(a_write_src, ram_we, (state_q == S_CLEAR) || (finish && in_range_q), "store write outside sweep or write-back")
  // A load leaves its entry with zero velocity.
  `NMU_ASSERT_IMP(a_load_zero_vel, (state_q == S_DONE) && (cmd_q == nmu_pkg::CMD_LOAD), v_new_q == '0, "load item with nonzero velocity")
  // An index beyond the store reports zero weight and velocity.
  `NMU_ASSERT_IMP(a_oor_zero, (state_q == S_DONE) && !in_range_q, (w_new_q == '0) && (v_new_q == '0), "out-of-range item with nonzero result")
  // A result only appears after an item finished.
  `NMU_ASSERT_NXT(a_out_after_done, (state_q != S_DONE) && !out_valid_q, !out_valid_q, "result without a finished item")

endmodule

FILE: verif/nmu_checker.sv
module nmu_checker #(
  parameter int NUM_PARAMS = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  nmu_in_if                             req_mon,
  nmu_out_if                            rsp_mon,
  input  logic                          cfg_we_i,
  input  logic [nmu_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [nmu_pkg::CFG_W-1:0]     cfg_data_i,
  output int unsigned                   outstanding_o,
  output int unsigned                   mismatch_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_W = nmu_pkg::IDX_W;
  localparam int VAL_W = nmu_pkg::VAL_W;
  localparam int CFG_W = nmu_pkg::CFG_W;

  localparam longint Q824_HI   = 64'sd2147483647;
  localparam longint Q824_LO   = -64'sd2147483648;
  localparam longint UNITY_Q16 = 64'sd65536;
  localparam longint HALF_LSB  = 64'sd32768;

  typedef struct packed {
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] weight;
    logic signed [VAL_W-1:0] velocity;
  } param_result_t;

  logic signed [VAL_W-1:0] weight_mem   [NUM_PARAMS];
  logic signed [VAL_W-1:0] velocity_mem [NUM_PARAMS];
  logic [CFG_W-1:0]        lr_q;
  logic [CFG_W-1:0]        rho_q;
  param_result_t           awaited_q [$];
  int unsigned             mismatches;

  function automatic logic signed [VAL_W-1:0] clamp_q824(input longint x);
    if (x > Q824_HI) begin
      return VAL_W'(Q824_HI);
    end else if (x < Q824_LO) begin
      return VAL_W'(Q824_LO);
    end
    return VAL_W'(x);
  endfunction

  // Q.40 to Q8.24, round half up; the arithmetic shift is a floor division.
  function automatic longint round_to_q824(input longint x);
    return (x + HALF_LSB) >>> 16;
  endfunction

  // Applies one item to the shadow stores and returns the result it causes.
  function automatic param_result_t advance_entry(input logic cmd,
                                                  input logic [IDX_W-1:0] idx,
                                                  input logic signed [VAL_W-1:0] operand);
    param_result_t r;
    longint rho;
    longint lr;
    longint v_old;
    longint w_old;
    longint vel_sum;
    longint w_step;
    r.index    = idx;
    r.weight   = '0;
    r.velocity = '0;
    if (int'(idx) < NUM_PARAMS) begin
      if (cmd == nmu_pkg::CMD_LOAD) begin
        r.weight = operand;
      end else begin
        rho        = longint'(rho_q);
        lr         = longint'(lr_q);
        v_old      = longint'(velocity_mem[idx]);
        w_old      = longint'(weight_mem[idx]);
        vel_sum    = rho * v_old - lr * longint'(operand);
        r.velocity = clamp_q824(round_to_q824(vel_sum));
        w_step     = (UNITY_Q16 + rho) * longint'(r.velocity) - rho * v_old;
        r.weight   = clamp_q824(w_old + round_to_q824(w_step));
      end
      velocity_mem[idx] = r.velocity;
      weight_mem[idx]   = r.weight;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    param_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PARAMS; i++) begin
        weight_mem[i]   = '0;
        velocity_mem[i] = '0;
      end
      lr_q  = nmu_pkg::LR_RESET;
      rho_q = nmu_pkg::RHO_RESET;
      awaited_q.delete();
      mismatches = 0;
      outstanding_o    <= 0;
      mismatch_count_o <= 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (awaited_q.size() == 0) begin
          $error("result for index %0d arrived with nothing awaited", rsp_mon.out_index);
          mismatches++;
        end else begin
          want = awaited_q.pop_front();
          if (rsp_mon.out_index !== want.index) begin
            $error("out_index: expected %0d, actual %0d", want.index, rsp_mon.out_index);
            mismatches++;
          end
          if (rsp_mon.new_weight !== want.weight) begin
            $error("new_weight: expected %0d, actual %0d",
                   $signed(want.weight), $signed(rsp_mon.new_weight));
            mismatches++;
          end
          if (rsp_mon.new_velocity !== want.velocity) begin
            $error("new_velocity: expected %0d, actual %0d",
                   $signed(want.velocity), $signed(rsp_mon.new_velocity));
            mismatches++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        awaited_q.push_back(advance_entry(req_mon.cmd, req_mon.param_index,
                                          req_mon.operand_value));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          nmu_pkg::CFG_STEP_SIZE:      lr_q  = cfg_data_i;
          nmu_pkg::CFG_MOMENTUM_DECAY: rho_q = cfg_data_i;
          default: ;
        endcase
      end
      outstanding_o    <= awaited_q.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

FILE: verif/tb_top.sv
module tb_top ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ENTRIES = 4096;

  localparam int IDX_W     = nmu_pkg::IDX_W;
  localparam int VAL_W     = nmu_pkg::VAL_W;
  localparam int CFG_W     = nmu_pkg::CFG_W;
  localparam int CFG_IDX_W = nmu_pkg::CFG_IDX_W;

  // Q8.24 values used by the directed part.
  localparam logic signed [VAL_W-1:0] Q_MAX  = 32'sh7FFFFFFF;
  localparam logic signed [VAL_W-1:0] Q_MIN  = 32'sh80000000;
  localparam logic signed [VAL_W-1:0] Q_ONE  = 32'sh01000000;
  localparam logic signed [VAL_W-1:0] Q_LSB  = 32'sh00000001;
  localparam logic signed [VAL_W-1:0] Q_ZERO = 32'sh00000000;

  // Register indexes that the block does not decode; writes there must do nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam logic [CFG_W-1:0]     CFG_FULL    = 16'hFFFF;
  localparam logic [CFG_W-1:0]     CFG_ZERO    = 16'h0000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 rsp_ready_q = 1'b0;
  int unsigned          ready_run_left = 0;
  int unsigned          outstanding;
  int unsigned          mismatch_count;
  int unsigned          burst_left;
  int unsigned          loads_sent;
  int unsigned          updates_sent;
  int unsigned          settings_used;

  nmu_in_if  req_if ();
  nmu_out_if rsp_if ();

  assign rsp_if.ready = rsp_ready_q;

  nesterov_momentum_update #(
    .NUM_PARAMS(NUM_ENTRIES)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // The checker shadows both stores and the registers, predicts every result
  // and compares it; it reports how many results are still awaited.
  nmu_checker #(
    .NUM_PARAMS(NUM_ENTRIES)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_mon          (req_if),
    .rsp_mon          (rsp_if),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .outstanding_o    (outstanding),
    .mismatch_count_o (mismatch_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The receiver mixes runs of ready and stalled cycles. Short runs put
  // back-pressure on the done state of the sequencer, long stalls fill the output
  // register and hold the next item at write-back, and the long ready runs
  // give stretches where the output side never stalls.
  always @(posedge clk_i) begin
    int unsigned pick;
    if (ready_run_left == 0) begin
      pick = $urandom_range(0, 7);
      if (pick == 0) begin
        rsp_ready_q    <= 1'b1;
        ready_run_left = $urandom_range(60, 200);
      end else if (pick <= 3) begin
        rsp_ready_q    <= 1'b0;
        ready_run_left = $urandom_range(1, 12);
      end else if (pick == 4) begin
        rsp_ready_q    <= 1'b0;
        ready_run_left = $urandom_range(20, 40);
      end else begin
        rsp_ready_q    <= 1'b1;
        ready_run_left = $urandom_range(1, 8);
      end
    end else begin
      ready_run_left--;
    end
  end

  // Offers one item and returns in the time step of the edge that took it.
  // Items go out in bursts; between bursts valid drops for a random gap, so
  // the pauses land at different points of the block's update sequence.
  task automatic issue(input logic cmd, input logic [IDX_W-1:0] idx,
                       input logic signed [VAL_W-1:0] operand);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 6);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
    end
    req_if.valid         <= 1'b1;
    req_if.cmd           <= cmd;
    req_if.param_index   <= idx;
    req_if.operand_value <= operand;
    do @(posedge clk_i); while (!req_if.ready);
    burst_left--;
    if (cmd == nmu_pkg::CMD_LOAD) begin
      loads_sent++;
    end else begin
      updates_sent++;
    end
  endtask

  // Stops sending and waits until every predicted result has been taken.
  // The checker's count is registered, so the loop sees it as of the edge before.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // Writes both registers, then a random value to an undecoded index.
  // Only called while the block is idle.
  task automatic apply_settings(input logic [CFG_W-1:0] lr, input logic [CFG_W-1:0] rho);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= nmu_pkg::CFG_STEP_SIZE;
    cfg_data_i <= lr;
    @(posedge clk_i);
    cfg_idx_i  <= nmu_pkg::CFG_MOMENTUM_DECAY;
    cfg_data_i <= rho;
    @(posedge clk_i);
    cfg_idx_i  <= ($urandom_range(0, 1) == 0) ? CFG_SPARE_A : CFG_SPARE_B;
    cfg_data_i <= CFG_W'($urandom);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    settings_used++;
  endtask

  // Most operands are moderate so that chains build up velocity without
  // clamping at once; the rest are full-range words and the extremes.
  function automatic logic signed [VAL_W-1:0] random_operand();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return Q_MAX;
          1:       return Q_MIN;
          2:       return Q_ZERO;
          default: return ($urandom_range(0, 1) == 0) ? Q_LSB : -Q_LSB;
        endcase
      end
      1, 2:    return VAL_W'($urandom);
      default: return VAL_W'($signed($urandom_range(0, 2 ** 26)) - 2 ** 25);
    endcase
  endfunction

  // A small hot set makes back-to-back hits on one entry common, which is
  // what exercises reads of an entry just written back; the top of the store
  // and the full range are visited too.
  function automatic logic [IDX_W-1:0] random_index();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return IDX_W'($urandom_range(0, 7));
      6, 7:             return IDX_W'($urandom_range(NUM_ENTRIES - 8, NUM_ENTRIES - 1));
      default:          return IDX_W'($urandom);
    endcase
  endfunction

  // Mostly training-like chains on one entry (often starting with a load),
  // mixed with single items of any kind as noise.
  task automatic run_random_items(input int unsigned count);
    int unsigned done;
    int unsigned chain;
    logic [IDX_W-1:0] idx;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 9) < 7) begin
        idx = random_index();
        if ($urandom_range(0, 2) != 0) begin
          issue(nmu_pkg::CMD_LOAD, idx, random_operand());
          done++;
        end
        chain = $urandom_range(1, 6);
        repeat (chain) issue(nmu_pkg::CMD_UPDATE, idx, random_operand());
        done += chain;
      end else begin
        issue(($urandom_range(0, 1) == 0) ? nmu_pkg::CMD_UPDATE : nmu_pkg::CMD_LOAD,
              random_index(), VAL_W'($urandom));
        done++;
      end
    end
  endtask

  task automatic random_phase(input logic [CFG_W-1:0] lr, input logic [CFG_W-1:0] rho,
                              input int unsigned count);
    apply_settings(lr, rho);
    run_random_items(count);
    drain_results();
  endtask

  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = nmu_pkg::CFG_STEP_SIZE;
    cfg_data_i           = '0;
    req_if.valid         = 1'b0;
    req_if.cmd           = nmu_pkg::CMD_UPDATE;
    req_if.param_index   = '0;
    req_if.operand_value = '0;
    burst_left           = 0;
    loads_sent           = 0;
    updates_sent         = 0;
    settings_used        = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed items under the reset values of the registers. The first one
    // reads an entry that only the reset sweep has written.
    issue(nmu_pkg::CMD_UPDATE, 12'd0, Q_ZERO);
    issue(nmu_pkg::CMD_UPDATE, IDX_W'(NUM_ENTRIES - 1), Q_MAX);
    issue(nmu_pkg::CMD_UPDATE, IDX_W'(NUM_ENTRIES - 1), Q_MIN);
    issue(nmu_pkg::CMD_LOAD, 12'd1, Q_MAX);
    issue(nmu_pkg::CMD_LOAD, 12'd2, Q_MIN);
    issue(nmu_pkg::CMD_LOAD, 12'd3, Q_ONE);
    // Back-to-back updates of one entry must see each other's write-back.
    issue(nmu_pkg::CMD_UPDATE, 12'd3, Q_ONE);
    issue(nmu_pkg::CMD_UPDATE, 12'd3, Q_ONE);
    issue(nmu_pkg::CMD_UPDATE, 12'd3, -Q_ONE);
    drain_results();

    // Largest factors: the velocity and then the weight clamp at both ends.
    apply_settings(CFG_FULL, CFG_FULL);
    issue(nmu_pkg::CMD_LOAD, 12'd5, Q_MAX);
    issue(nmu_pkg::CMD_UPDATE, 12'd5, Q_MIN);
    issue(nmu_pkg::CMD_UPDATE, 12'd5, Q_MIN);
    issue(nmu_pkg::CMD_LOAD, 12'd6, Q_MIN);
    issue(nmu_pkg::CMD_UPDATE, 12'd6, Q_MAX);
    issue(nmu_pkg::CMD_UPDATE, 12'd6, Q_MAX);
    // One-LSB gradients land on the rounding boundary.
    issue(nmu_pkg::CMD_LOAD, IDX_W'(NUM_ENTRIES - 1), Q_ZERO);
    issue(nmu_pkg::CMD_UPDATE, IDX_W'(NUM_ENTRIES - 1), Q_LSB);
    issue(nmu_pkg::CMD_UPDATE, IDX_W'(NUM_ENTRIES - 1), -Q_LSB);
    drain_results();

    // Zero factors: velocity collapses to zero and the weight holds.
    apply_settings(CFG_ZERO, CFG_ZERO);
    issue(nmu_pkg::CMD_UPDATE, 12'd3, Q_MAX);
    issue(nmu_pkg::CMD_UPDATE, 12'd7, -Q_LSB);
    drain_results();

    // Random part, about 900 items over several register settings.
    random_phase(CFG_FULL, CFG_FULL, 120);
    random_phase(CFG_ZERO, CFG_ZERO, 100);
    random_phase(CFG_FULL, CFG_ZERO, 100);
    random_phase(CFG_ZERO, CFG_FULL, 100);
    random_phase(nmu_pkg::LR_RESET, nmu_pkg::RHO_RESET, 180);
    repeat (2) random_phase(CFG_W'($urandom), CFG_W'($urandom), 150);

    // Nothing is awaited any more; give the block a few more update times
    // so that a stray late result would still be caught.
    repeat (30) @(posedge clk_i);

    $display("Covered %0d load and %0d update items over %0d register settings,",
             loads_sent, updates_sent, settings_used);
    $display("with bursty input and a stalling receiver; %0d mismatches seen.",
             mismatch_count);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Far beyond the slowest correct run, including the reset sweep.
  initial begin
    #5ms;
    $display("Timeout with %0d results still awaited", outstanding);
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/nmu_pkg.sv
rtl/core/nmu_in_if.sv
rtl/core/nmu_out_if.sv
rtl/core/nmu_ram.sv
rtl/core/nmu_mul.sv
rtl/core/nesterov_momentum_update.sv
verif/nmu_checker.sv
verif/tb_top.sv
